>>> hdl/trifocal_point_transfer_error_unit_macros.svh
// ----------------------------------------------------------------------------
// Trifocal point transfer error unit: assertion macros
// Immediate-style wrappers around concurrent assertions; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIFOCAL_POINT_TRANSFER_ERROR_UNIT_MACROS_SVH
`define TRIFOCAL_POINT_TRANSFER_ERROR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TPTE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication
`define TPTE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TPTE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define TPTE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/tpte_pkg.sv
// ----------------------------------------------------------------------------
// Trifocal point transfer error package
// Widths, formats, payload types and codes shared by the scoring pipeline.
// ----------------------------------------------------------------------------
package tpte_pkg;

    // Field widths
    localparam int COORD_WIDTH = 24;
    localparam int COEF_WIDTH  = 32;
    localparam int FRAC_COORD  = 8;
    localparam int NUM_COEF    = 27;
    localparam int IDX_W       = 5;
    localparam int TAG_W       = 16;
    localparam int ERR_W       = 48;

    // Product of a coordinate and a coefficient
    localparam int PROD_W  = COORD_WIDTH + COEF_WIDTH;
    // Shifted third-row coefficient
    localparam int T2_W    = COEF_WIDTH + FRAC_COORD;
    // Line term: sum of two products and one shifted coefficient
    localparam int LINE_W  = COORD_WIDTH + COEF_WIDTH + 1;
    // Line term times a coordinate, cut into chunks
    localparam int CHUNK_W = 32;
    localparam int NCHUNK  = (LINE_W + CHUNK_W - 1) / CHUNK_W;
    localparam int LEXT_W  = NCHUNK * CHUNK_W;
    localparam int CPROD_W = CHUNK_W + 1 + COORD_WIDTH;
    // Homogeneous numerators and denominator
    localparam int HOM_W   = LINE_W + COORD_WIDTH + 1;
    // Divider
    localparam int QUOT_W  = 41;
    localparam int DNUM_W  = HOM_W + FRAC_COORD;
    localparam int DIV_LAT = QUOT_W + 1;
    // Prediction and difference
    localparam int PRED_W  = QUOT_W + 1;
    localparam int DIFF_W  = ((COORD_WIDTH > PRED_W) ? COORD_WIDTH : PRED_W) + 1;
    localparam int SQ_IN_W = 24;

    localparam logic [QUOT_W-1:0] QUOT_CLAMP = {1'b1, {(QUOT_W-1){1'b0}}};
    localparam logic [ERR_W-1:0]  ERR_MAX    = {ERR_W{1'b1}};

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_SCORE = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t                        action;
        logic [IDX_W-1:0]               coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
        logic [TAG_W-1:0]               point_tag;
        logic signed [COORD_WIDTH-1:0]  first_x;
        logic signed [COORD_WIDTH-1:0]  first_y;
        logic signed [COORD_WIDTH-1:0]  second_x;
        logic signed [COORD_WIDTH-1:0]  second_y;
        logic signed [COORD_WIDTH-1:0]  third_x;
        logic signed [COORD_WIDTH-1:0]  third_y;
    } item_t;

    typedef struct packed
    {
        logic [TAG_W-1:0] result_tag;
        logic [ERR_W-1:0] squared_error;
        logic             zero_denominator;
    } result_t;

    // Tag and observation carried down the pipeline
    typedef struct packed
    {
        logic [TAG_W-1:0]               tag;
        logic signed [COORD_WIDTH-1:0]  obs_x;
        logic signed [COORD_WIDTH-1:0]  obs_y;
    } tail_t;

    // Quotient signs and zero-denominator flag
    typedef struct packed
    {
        logic neg_x;
        logic neg_y;
        logic zero;
    } sign_t;

endpackage

>>> hdl/tpte_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, plus an overflow flag for quotients that do not
// fit in QUOT_W bits. All stages advance together on en.
// ----------------------------------------------------------------------------
module tpte_divider #(
    parameter int NUM_W  = tpte_pkg::DNUM_W,
    parameter int DEN_W  = tpte_pkg::HOM_W,
    parameter int QUOT_W = tpte_pkg::QUOT_W
) (
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUOT_W-1:0] quot,
    output logic              ovf
);

    localparam int XW = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

    logic [NUM_W-1:0]  rem_reg [QUOT_W+1];
    logic [DEN_W-1:0]  den_reg [QUOT_W+1];
    logic [QUOT_W-1:0] q_reg   [QUOT_W+1];
    logic              ovf_reg [QUOT_W+1];

    // Load operands and flag quotients of 2^QUOT_W or more
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= XW'(num) >= (XW'(den) << QUOT_W);
        end
    end

    // Subtract the shifted divisor, one bit per stage, most significant first
    for (genvar s = 0; s < QUOT_W; s++)
    begin : g_step
        localparam int B = QUOT_W - 1 - s;
        logic [XW-1:0]     rem_x;
        logic [XW-1:0]     sub_x;
        logic              ge;
        logic [NUM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] q_next;

        always_comb
        begin
            rem_x    = XW'(rem_reg[s]);
            sub_x    = XW'(den_reg[s]) << B;
            ge       = rem_x >= sub_x;
            rem_next = ge ? NUM_W'(rem_x - sub_x) : rem_reg[s];
            q_next    = q_reg[s];
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_next;
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign quot = q_reg[QUOT_W];
    assign ovf  = ovf_reg[QUOT_W];

endmodule

>>> hdl/trifocal_point_transfer_error_unit.sv
// ----------------------------------------------------------------------------
// Trifocal point transfer error unit
// Scores point triples against a trifocal tensor held in a 27-entry store.
//
//   Channel   Handshake                   Payload            Moves
//   item      item_valid / item_ready     item   (item_t)    load or point
//   result    result_valid / result_ready result (result_t)  one per point
//
// One item per cycle while no result is stalled. A point's result passes
// through five arithmetic stages, a 42-stage divider (one quotient bit per
// stage), and three stages for difference, square and sum. A load writes
// the store at its transfer and yields no result. A stall at the result port
// freezes the whole pipeline; item_ready drops only while a result waits.
// Reset clears valid bits only; the store holds garbage until written.
// ----------------------------------------------------------------------------
`include "trifocal_point_transfer_error_unit_macros.svh"

module trifocal_point_transfer_error_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tpte_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tpte_pkg::result_t result
);

    import tpte_pkg::*;

    localparam int NST    = 5 + DIV_LAT + 3;
    localparam int NTAIL  = 5 + DIV_LAT;
    localparam int NSIGN  = DIV_LAT + 1;

    logic adv;
    logic point_xfer;
    logic load_xfer;
    logic [NST-1:0] valid_reg;

    logic signed [COEF_WIDTH-1:0] store_reg [NUM_COEF];

    // Stage 1: products
    logic signed [PROD_W-1:0] px_next [2][3];
    logic signed [PROD_W-1:0] py_next [2][3];
    logic signed [T2_W-1:0]   t2_next [2][3];
    logic signed [PROD_W-1:0] px_reg  [2][3];
    logic signed [PROD_W-1:0] py_reg  [2][3];
    logic signed [T2_W-1:0]   t2_reg  [2][3];
    logic signed [COORD_WIDTH-1:0] x2_reg [2];
    logic signed [COORD_WIDTH-1:0] y2_reg [2];

    // Stage 2: line terms
    logic signed [LINE_W-1:0] line_next [2][3];
    logic signed [LINE_W-1:0] line_reg  [2][3];

    // Stage 3: chunk products
    logic signed [CPROD_W-1:0] ap_next [3][NCHUNK];
    logic signed [CPROD_W-1:0] bp_next [3][NCHUNK];
    logic signed [CPROD_W-1:0] ap_reg  [3][NCHUNK];
    logic signed [CPROD_W-1:0] bp_reg  [3][NCHUNK];

    // Stage 4: homogeneous terms
    logic signed [HOM_W-1:0] n_next [3];
    logic signed [HOM_W-1:0] n_reg  [3];

    // Stage 5: magnitudes
    logic [HOM_W-1:0] numx_reg;
    logic [HOM_W-1:0] numy_reg;
    logic [HOM_W-1:0] den_reg;
    sign_t            sign_next;
    sign_t            sign_reg [NSIGN];
    tail_t            tail_reg [NTAIL];

    // Divider outputs
    logic [QUOT_W-1:0] qx;
    logic [QUOT_W-1:0] qy;
    logic              ovfx;
    logic              ovfy;

    // Final stages
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic [TAG_W-1:0]         tag1_reg;
    logic                     zero1_reg;
    logic [DIFF_W-1:0]        magx;
    logic [DIFF_W-1:0]        magy;
    logic [ERR_W-1:0]         sqx_reg;
    logic [ERR_W-1:0]         sqy_reg;
    logic                     sat2_reg;
    logic                     zero2_reg;
    logic [TAG_W-1:0]         tag2_reg;
    logic [ERR_W:0]           sum;
    result_t                  out_next;
    result_t                  out_reg;

    // Advance whenever the output register is free or being emptied
    assign adv          = !valid_reg[NST-1] || result_ready;
    assign item_ready   = adv;
    assign point_xfer   = item_valid && adv && (item.action == ACT_SCORE);
    assign load_xfer    = item_valid && adv && (item.action == ACT_LOAD);
    assign result_valid = valid_reg[NST-1];
    assign result       = out_reg;

    // Move valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[NST-2:0], point_xfer};
        end
    end

    // Write one coefficient; drop out-of-range positions
    always_ff @(posedge clk)
    begin
        if (load_xfer && (item.coef_index < IDX_W'(NUM_COEF)))
        begin
            store_reg[item.coef_index] <= item.coef_value;
        end
    end

    // Form the coordinate-by-coefficient products for rows j = 0 and 1
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                px_next[j][k] = item.first_x * store_reg[j*3 + k];
                py_next[j][k] = item.first_y * store_reg[9 + j*3 + k];
                t2_next[j][k] = $signed({store_reg[18 + j*3 + k], {FRAC_COORD{1'b0}}});
            end
        end
    end

    // Sum each line term
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                line_next[j][k] = LINE_W'(px_reg[j][k]) + LINE_W'(py_reg[j][k])
                                + LINE_W'(t2_reg[j][k]);
            end
        end
    end

    // Multiply line terms by the second-view coordinates in 32-bit chunks
    for (genvar k = 0; k < 3; k++)
    begin : g_chunk_k
        logic signed [LEXT_W-1:0] la;
        logic signed [LEXT_W-1:0] lb;
        assign la = LEXT_W'(line_reg[1][k]);
        assign lb = LEXT_W'(line_reg[0][k]);
        for (genvar c = 0; c < NCHUNK; c++)
        begin : g_chunk_c
            logic signed [CHUNK_W:0] ca;
            logic signed [CHUNK_W:0] cb;
            if (c == NCHUNK - 1)
            begin : g_top
                assign ca = (CHUNK_W+1)'($signed(la[c*CHUNK_W +: CHUNK_W]));
                assign cb = (CHUNK_W+1)'($signed(lb[c*CHUNK_W +: CHUNK_W]));
            end
            else
            begin : g_low
                assign ca = $signed({1'b0, la[c*CHUNK_W +: CHUNK_W]});
                assign cb = $signed({1'b0, lb[c*CHUNK_W +: CHUNK_W]});
            end
            assign ap_next[k][c] = ca * x2_reg[1];
            assign bp_next[k][c] = cb * y2_reg[1];
        end
    end

    // Combine chunks and take the difference
    always_comb
    begin
        logic signed [HOM_W-1:0] a;
        logic signed [HOM_W-1:0] b;
        for (int k = 0; k < 3; k++)
        begin
            a = '0;
            b = '0;
            for (int c = 0; c < NCHUNK; c++)
            begin
                a = a + (HOM_W'(ap_reg[k][c]) <<< (c*CHUNK_W));
                b = b + (HOM_W'(bp_reg[k][c]) <<< (c*CHUNK_W));
            end
            n_next[k] = a - b;
        end
    end

    // Signs of the two quotients and the zero check
    always_comb
    begin
        sign_next.neg_x = n_reg[0][HOM_W-1] ^ n_reg[2][HOM_W-1];
        sign_next.neg_y = n_reg[1][HOM_W-1] ^ n_reg[2][HOM_W-1];
        sign_next.zero  = (n_reg[2] == '0);
    end

    // Front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            t2_reg    <= t2_next;
            x2_reg[0] <= item.second_x;
            y2_reg[0] <= item.second_y;
            line_reg  <= line_next;
            x2_reg[1] <= x2_reg[0];
            y2_reg[1] <= y2_reg[0];
            ap_reg    <= ap_next;
            bp_reg    <= bp_next;
            n_reg     <= n_next;
            numx_reg  <= n_reg[0][HOM_W-1] ? HOM_W'(-n_reg[0]) : HOM_W'(n_reg[0]);
            numy_reg  <= n_reg[1][HOM_W-1] ? HOM_W'(-n_reg[1]) : HOM_W'(n_reg[1]);
            den_reg   <= n_reg[2][HOM_W-1] ? HOM_W'(-n_reg[2]) : HOM_W'(n_reg[2]);
        end
    end

    // Carry tag, observations and signs alongside the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg[0] <= '{tag: item.point_tag, obs_x: item.third_x, obs_y: item.third_y};
            for (int t = 1; t < NTAIL; t++)
            begin
                tail_reg[t] <= tail_reg[t-1];
            end
            sign_reg[0] <= sign_next;
            for (int t = 1; t < NSIGN; t++)
            begin
                sign_reg[t] <= sign_reg[t-1];
            end
        end
    end

    tpte_divider #(
        .NUM_W  (DNUM_W),
        .DEN_W  (HOM_W),
        .QUOT_W (QUOT_W)
    ) u_div_x (
        .clk  (clk),
        .en   (adv),
        .num  ({numx_reg, {FRAC_COORD{1'b0}}}),
        .den  (den_reg),
        .quot (qx),
        .ovf  (ovfx)
    );

    tpte_divider #(
        .NUM_W  (DNUM_W),
        .DEN_W  (HOM_W),
        .QUOT_W (QUOT_W)
    ) u_div_y (
        .clk  (clk),
        .en   (adv),
        .num  ({numy_reg, {FRAC_COORD{1'b0}}}),
        .den  (den_reg),
        .quot (qy),
        .ovf  (ovfy)
    );

    // Clamp the quotients, apply signs, subtract from the observations
    always_comb
    begin
        logic [QUOT_W-1:0]        mx;
        logic [QUOT_W-1:0]        my;
        logic signed [PRED_W-1:0] predx;
        logic signed [PRED_W-1:0] predy;
        mx = (ovfx || (qx[QUOT_W-1] && (qx[QUOT_W-2:0] != '0))) ? QUOT_CLAMP : qx;
        my = (ovfy || (qy[QUOT_W-1] && (qy[QUOT_W-2:0] != '0))) ? QUOT_CLAMP : qy;
        predx = sign_reg[NSIGN-1].neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        predy = sign_reg[NSIGN-1].neg_y ? -$signed({1'b0, my}) : $signed({1'b0, my});
        dx_next = DIFF_W'(tail_reg[NTAIL-1].obs_x) - DIFF_W'(predx);
        dy_next = DIFF_W'(tail_reg[NTAIL-1].obs_y) - DIFF_W'(predy);
    end

    // Magnitudes of the differences
    assign magx = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
    assign magy = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);

    // Sum the squares and saturate
    always_comb
    begin
        sum = (ERR_W+1)'(sqx_reg) + (ERR_W+1)'(sqy_reg);
        out_next.result_tag       = tag2_reg;
        out_next.zero_denominator = zero2_reg;
        if (zero2_reg || sat2_reg || sum[ERR_W])
        begin
            out_next.squared_error = ERR_MAX;
        end
        else
        begin
            out_next.squared_error = sum[ERR_W-1:0];
        end
    end

    // Back stages and output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            tag1_reg  <= tail_reg[NTAIL-1].tag;
            zero1_reg <= sign_reg[NSIGN-1].zero;
            sqx_reg   <= magx[SQ_IN_W-1:0] * magx[SQ_IN_W-1:0];
            sqy_reg   <= magy[SQ_IN_W-1:0] * magy[SQ_IN_W-1:0];
            sat2_reg  <= (magx[DIFF_W-1:SQ_IN_W] != '0) || (magy[DIFF_W-1:SQ_IN_W] != '0);
            zero2_reg <= zero1_reg;
            tag2_reg  <= tag1_reg;
            out_reg   <= out_next;
        end
    end

    `TPTE_ASSERT_IMP(a_zero_saturates, clk, rst_n, result_valid && result.zero_denominator, result.squared_error == ERR_MAX)
    `TPTE_ASSERT_NEXT(a_stall_freezes, clk, rst_n, result_valid && !result_ready, $stable(valid_reg))
    `TPTE_ASSERT_NEXT(a_load_no_result, clk, rst_n, load_xfer, !valid_reg[0])

endmodule
